// ===== src/assert_macros.svh =====
// Assertion macros shared by the RTL; empty when synthesizing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define I2C_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");
`define I2C_NEVER(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("forbidden condition seen");
`else
`define I2C_ASSERT(label, clk, rst_n, prop)
`define I2C_NEVER(label, clk, rst_n, cond)
`endif
`endif

// ===== src/i2cms_pkg.sv =====
// Shared types and codes for the I2C master transfer sequencer.
package i2cms_pkg;

	localparam int BUF_DEPTH_DEFAULT = 16;

	typedef logic [1:0] opcode_t;
	typedef logic [1:0] ack_t;
	typedef logic [7:0] byte_t;

	localparam opcode_t OP_LOAD     = 2'd0;
	localparam opcode_t OP_START_WR = 2'd1;
	localparam opcode_t OP_START_RD = 2'd2;
	localparam opcode_t OP_STATUS   = 2'd3;

	localparam ack_t ACK_KEEP  = 2'd0;
	localparam ack_t ACK_SET   = 2'd1;
	localparam ack_t ACK_CLEAR = 2'd2;

	localparam byte_t ST_START_SENT = 8'h08;
	localparam byte_t ST_SLA_W_ACK  = 8'h18;
	localparam byte_t ST_DATA_ACK   = 8'h28;
	localparam byte_t ST_SLA_R_ACK  = 8'h40;
	localparam byte_t ST_SLA_R_NACK = 8'h48;
	localparam byte_t ST_RX_ACK     = 8'h50;
	localparam byte_t ST_RX_NACK    = 8'h58;

	localparam logic [4:0] POS_MAX = 5'd31;

endpackage

// ===== src/i2cms_buffer.sv =====
// Byte buffer: one write port, one registered read port with write-through.
module i2cms_buffer #(
	parameter int DEPTH = i2cms_pkg::BUF_DEPTH_DEFAULT,
	parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                 clk,
	input  logic                 wr_en,
	input  logic [AW-1:0]        wr_addr,
	input  i2cms_pkg::byte_t     wr_data,
	input  logic [AW-1:0]        rd_addr,
	output i2cms_pkg::byte_t     rd_data
);
	import i2cms_pkg::*;

	byte_t mem [DEPTH];
	byte_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// read data for the next cycle; a write to the same entry wins
	always_ff @(posedge clk) begin
		if (wr_en && (wr_addr == rd_addr)) begin
			rd_data_q <= wr_data;
		end else begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== src/i2c_master_transfer_sequencer.sv =====
// Top level of the I2C master transfer sequencer.
//
//   channel  dir  handshake            payload
//   in       in   in_valid/in_ready    opcode .. rx_byte
//   out      out  out_valid/out_ready  tx_valid .. start_rejected
//
// One result per item; an item enters every cycle when the result side keeps up.
// Each item passes the input register, then is decoded into the result register.
// Buffer byte for the current position is prefetched from the buffer memory.
// Reset clears control and sequencing state; buffer contents are undefined.
// A stalled result holds and backs up into the input register, then in_ready.
module i2c_master_transfer_sequencer #(
	parameter int BUF_DEPTH = i2cms_pkg::BUF_DEPTH_DEFAULT
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  i2cms_pkg::opcode_t    opcode,
	input  logic [6:0]            target_address,
	input  logic [4:0]            byte_count,
	input  logic [3:0]            buffer_index,
	input  i2cms_pkg::byte_t      load_byte,
	input  i2cms_pkg::byte_t      status_code,
	input  i2cms_pkg::byte_t      rx_byte,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic                  tx_valid,
	output i2cms_pkg::byte_t      tx_byte,
	output logic                  send_start,
	output logic                  send_stop,
	output i2cms_pkg::ack_t       ack_control,
	output logic                  clear_start,
	output logic                  clear_interrupt,
	output logic                  rx_valid,
	output i2cms_pkg::byte_t      rx_data,
	output logic [3:0]            rx_position,
	output logic                  busy_res,
	output logic                  start_rejected
);
	import i2cms_pkg::*;

	localparam int AW = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
	localparam logic [8:0] DEPTH9 = 9'(BUF_DEPTH);

	// input register
	logic       valid_s1;
	opcode_t    op_s1;
	logic [6:0] addr_s1;
	logic [4:0] cnt_s1;
	logic [3:0] idx_s1;
	byte_t      load_s1;
	byte_t      status_s1;
	byte_t      rx_s1;

	// sequencing state
	logic [6:0] slave_addr_q;
	logic       read_dir_q;
	logic [4:0] total_q;
	logic [4:0] pos_q;
	logic       busy_q;

	logic [6:0] slave_addr_d;
	logic       read_dir_d;
	logic [4:0] total_d;
	logic [4:0] pos_d;
	logic       busy_d;

	// result register
	logic  out_valid_q;
	logic  tx_valid_q, send_start_q, send_stop_q, clear_start_q, clear_int_q;
	logic  rx_valid_q, busy_res_q, rejected_q;
	byte_t tx_byte_q, rx_data_q;
	ack_t  ack_q;
	logic [3:0] rx_pos_q;

	logic  r_tx_valid, r_send_start, r_send_stop, r_clear_start, r_clear_int;
	logic  r_rx_valid, r_rejected;
	byte_t r_tx_byte, r_rx_data;
	ack_t  r_ack;
	logic [3:0] r_rx_pos;

	logic          advance;
	logic          fire;
	logic          buf_we;
	logic [AW-1:0] buf_waddr;
	byte_t         buf_wdata;
	logic [AW-1:0] buf_raddr;
	byte_t         buf_rdata;

	logic [4:0] pos_inc;
	logic       pos_in_buf;
	byte_t      tx_buf;
	ack_t       ack_pick;
	ack_t       ack_rx;
	logic [8:0] pos_ext;
	logic [8:0] pos_d_ext;
	logic [8:0] idx_ext;
	logic [8:0] cnt_ext;

	assign advance  = !out_valid_q || out_ready;
	assign fire     = valid_s1 && advance;
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			op_s1     <= opcode;
			addr_s1   <= target_address;
			cnt_s1    <= byte_count;
			idx_s1    <= buffer_index;
			load_s1   <= load_byte;
			status_s1 <= status_code;
			rx_s1     <= rx_byte;
		end
	end

	assign pos_ext    = {4'd0, pos_q};
	assign idx_ext    = {5'd0, idx_s1};
	assign cnt_ext    = {4'd0, cnt_s1};
	assign pos_inc    = (pos_q != POS_MAX) ? pos_q + 5'd1 : pos_q;
	assign pos_in_buf = pos_ext < DEPTH9;
	assign tx_buf     = pos_in_buf ? buf_rdata : 8'd0;
	assign ack_pick   = (({1'b0, pos_q} + 6'd1) < {1'b0, total_q}) ? ACK_SET : ACK_CLEAR;
	// after a received byte the ACK decision looks at the advanced position
	assign ack_rx     = (({1'b0, pos_inc} + 6'd1) < {1'b0, total_q}) ? ACK_SET : ACK_CLEAR;

	always_comb begin
		slave_addr_d  = slave_addr_q;
		read_dir_d    = read_dir_q;
		total_d       = total_q;
		pos_d         = pos_q;
		busy_d        = busy_q;
		r_tx_valid    = 1'b0;
		r_tx_byte     = 8'd0;
		r_send_start  = 1'b0;
		r_send_stop   = 1'b0;
		r_ack         = ACK_KEEP;
		r_clear_start = 1'b0;
		r_clear_int   = 1'b0;
		r_rx_valid    = 1'b0;
		r_rx_data     = 8'd0;
		r_rx_pos      = 4'd0;
		r_rejected    = 1'b0;
		buf_we        = 1'b0;
		buf_waddr     = idx_ext[AW-1:0];
		buf_wdata     = load_s1;
		if (fire) begin
			unique case (op_s1)
				OP_LOAD: begin
					buf_we = !busy_q && (idx_ext < DEPTH9);
				end
				OP_START_WR, OP_START_RD: begin
					if (busy_q) begin
						r_rejected = 1'b1;
					end else begin
						slave_addr_d = addr_s1;
						read_dir_d   = (op_s1 == OP_START_RD);
						total_d      = (cnt_ext > DEPTH9) ? DEPTH9[4:0] : cnt_s1;
						pos_d        = 5'd0;
						busy_d       = 1'b1;
						r_send_start = 1'b1;
					end
				end
				OP_STATUS: begin
					unique case (status_s1)
						ST_START_SENT: begin
							r_tx_valid    = 1'b1;
							r_tx_byte     = {slave_addr_q, read_dir_q};
							r_clear_start = 1'b1;
							r_clear_int   = 1'b1;
						end
						ST_SLA_W_ACK: begin
							r_tx_valid  = 1'b1;
							r_tx_byte   = tx_buf;
							pos_d       = pos_inc;
							r_clear_int = 1'b1;
						end
						ST_DATA_ACK: begin
							if (pos_q < total_q) begin
								r_tx_valid = 1'b1;
								r_tx_byte  = tx_buf;
								pos_d      = pos_inc;
							end else begin
								busy_d      = 1'b0;
								r_send_stop = 1'b1;
							end
							r_clear_int = 1'b1;
						end
						ST_SLA_R_ACK: begin
							r_ack       = ack_pick;
							r_clear_int = 1'b1;
						end
						ST_SLA_R_NACK: begin
							busy_d      = 1'b0;
							r_send_stop = 1'b1;
							r_clear_int = 1'b1;
						end
						ST_RX_ACK, ST_RX_NACK: begin
							// received byte lands at the current position
							if (pos_in_buf) begin
								buf_we     = 1'b1;
								buf_waddr  = pos_ext[AW-1:0];
								buf_wdata  = rx_s1;
								r_rx_valid = 1'b1;
								r_rx_data  = rx_s1;
								r_rx_pos   = pos_q[3:0];
							end
							pos_d       = pos_inc;
							r_clear_int = 1'b1;
							if (status_s1 == ST_RX_ACK) begin
								r_ack = ack_rx;
							end else begin
								busy_d      = 1'b0;
								r_send_stop = 1'b1;
							end
						end
						default: begin
						end
					endcase
				end
				default: begin
				end
			endcase
		end
	end

	// prefetch the entry at the position the next item will see
	assign pos_d_ext = {4'd0, pos_d};
	assign buf_raddr = pos_d_ext[AW-1:0];

	i2cms_buffer #(
		.DEPTH(BUF_DEPTH),
		.AW(AW)
	) u_buffer (
		.clk(clk),
		.wr_en(buf_we),
		.wr_addr(buf_waddr),
		.wr_data(buf_wdata),
		.rd_addr(buf_raddr),
		.rd_data(buf_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slave_addr_q <= 7'd0;
			read_dir_q   <= 1'b0;
			total_q      <= 5'd0;
			pos_q        <= 5'd0;
			busy_q       <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			slave_addr_q <= slave_addr_d;
			read_dir_q   <= read_dir_d;
			total_q      <= total_d;
			pos_q        <= pos_d;
			busy_q       <= busy_d;
			if (advance) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			tx_valid_q    <= r_tx_valid;
			tx_byte_q     <= r_tx_byte;
			send_start_q  <= r_send_start;
			send_stop_q   <= r_send_stop;
			ack_q         <= r_ack;
			clear_start_q <= r_clear_start;
			clear_int_q   <= r_clear_int;
			rx_valid_q    <= r_rx_valid;
			rx_data_q     <= r_rx_data;
			rx_pos_q      <= r_rx_pos;
			busy_res_q    <= busy_d;
			rejected_q    <= r_rejected;
		end
	end

	assign out_valid       = out_valid_q;
	assign tx_valid        = tx_valid_q;
	assign tx_byte         = tx_byte_q;
	assign send_start      = send_start_q;
	assign send_stop       = send_stop_q;
	assign ack_control     = ack_q;
	assign clear_start     = clear_start_q;
	assign clear_interrupt = clear_int_q;
	assign rx_valid        = rx_valid_q;
	assign rx_data         = rx_data_q;
	assign rx_position     = rx_pos_q;
	assign busy_res        = busy_res_q;
	assign start_rejected  = rejected_q;

`include "assert_macros.svh"

	`I2C_NEVER(a_stop_while_busy, clk, arst_n, out_valid_q && send_stop_q && busy_res_q)
	`I2C_ASSERT(a_reject_only_busy, clk, arst_n, (out_valid_q && rejected_q) |-> busy_res_q)
	`I2C_ASSERT(a_start_sets_busy, clk, arst_n, (fire && !busy_q && (op_s1 == OP_START_WR || op_s1 == OP_START_RD)) |=> (busy_q && pos_q == 5'd0))

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for the I2C master transfer sequencer.
module testbench;
	import i2cms_pkg::*;

	localparam int DEPTH = BUF_DEPTH_DEFAULT;

	typedef struct packed {
		opcode_t    op;
		logic [6:0] addr;
		logic [4:0] cnt;
		logic [3:0] idx;
		byte_t      ld;
		byte_t      status;
		byte_t      rx;
		logic       drain_first;
	} bus_cmd_t;

	typedef struct packed {
		logic       tx_valid;
		byte_t      tx_byte;
		logic       send_start;
		logic       send_stop;
		ack_t       ack;
		logic       clear_start;
		logic       clear_interrupt;
		logic       rx_valid;
		byte_t      rx_data;
		logic [3:0] rx_pos;
		logic       busy;
		logic       rejected;
	} ctrl_action_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	opcode_t    opcode = OP_LOAD;
	logic [6:0] target_address = '0;
	logic [4:0] byte_count = '0;
	logic [3:0] buffer_index = '0;
	byte_t      load_byte = '0;
	byte_t      status_code = '0;
	byte_t      rx_byte = '0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic       tx_valid;
	byte_t      tx_byte;
	logic       send_start;
	logic       send_stop;
	ack_t       ack_control;
	logic       clear_start;
	logic       clear_interrupt;
	logic       rx_valid;
	byte_t      rx_data;
	logic [3:0] rx_position;
	logic       busy_res;
	logic       start_rejected;

	i2c_master_transfer_sequencer uut (.*);

	// shadow copy of the sequencer state
	byte_t      shadow_buf [DEPTH];
	logic [6:0] shadow_addr = '0;
	logic       shadow_rd = 1'b0;
	logic [4:0] shadow_total = '0;
	logic [4:0] shadow_pos = '0;
	logic       shadow_busy = 1'b0;

	bus_cmd_t     pending_cmds [$];
	ctrl_action_t pending_actions [$];
	bus_cmd_t     cur_cmd;
	int           offered_count = 0;
	int           accepted_count = 0;
	int           mismatches = 0;
	bit           drain_next = 1'b0;
	int           send_gap = 0;
	int           stall_left = 0;
	int           hold_left = 0;
	bit           long_hold_done = 1'b0;

	byte_t known_codes [7] = '{ST_START_SENT, ST_SLA_W_ACK, ST_DATA_ACK, ST_SLA_R_ACK,
		ST_SLA_R_NACK, ST_RX_ACK, ST_RX_NACK};

	initial begin
		forever #6 clk = ~clk;
	end

	function automatic void step_pos();
		if (shadow_pos != POS_MAX)
			shadow_pos = shadow_pos + 5'd1;
	endfunction

	function automatic byte_t take_tx_byte();
		byte_t b;
		b = (shadow_pos < DEPTH) ? shadow_buf[shadow_pos[3:0]] : 8'h00;
		step_pos();
		return b;
	endfunction

	function automatic ack_t ack_for_pos();
		return ({1'b0, shadow_pos} + 6'd1 < {1'b0, shadow_total}) ? ACK_SET : ACK_CLEAR;
	endfunction

	function automatic ctrl_action_t bus_controller_action(bus_cmd_t c);
		ctrl_action_t a;
		a = '0;
		case (c.op)
			OP_LOAD: begin
				if (!shadow_busy)
					shadow_buf[c.idx] = c.ld;
			end
			OP_START_WR, OP_START_RD: begin
				if (shadow_busy) begin
					a.rejected = 1'b1;
				end else begin
					shadow_addr = c.addr;
					shadow_rd = (c.op == OP_START_RD);
					shadow_total = (c.cnt > DEPTH) ? 5'(DEPTH) : c.cnt;
					shadow_pos = '0;
					shadow_busy = 1'b1;
					a.send_start = 1'b1;
				end
			end
			default: begin
				// received byte is stored and emitted before the position moves on
				if (c.status == ST_RX_ACK || c.status == ST_RX_NACK) begin
					if (shadow_pos < DEPTH) begin
						shadow_buf[shadow_pos[3:0]] = c.rx;
						a.rx_valid = 1'b1;
						a.rx_data = c.rx;
						a.rx_pos = shadow_pos[3:0];
					end
					step_pos();
				end
				a.clear_interrupt = 1'b1;
				case (c.status)
					ST_START_SENT: begin
						a.tx_valid = 1'b1;
						a.tx_byte = {shadow_addr, shadow_rd};
						a.clear_start = 1'b1;
					end
					ST_SLA_W_ACK: begin
						a.tx_valid = 1'b1;
						a.tx_byte = take_tx_byte();
					end
					ST_DATA_ACK: begin
						if (shadow_pos < shadow_total) begin
							a.tx_valid = 1'b1;
							a.tx_byte = take_tx_byte();
						end else begin
							shadow_busy = 1'b0;
							a.send_stop = 1'b1;
						end
					end
					ST_SLA_R_ACK, ST_RX_ACK: begin
						a.ack = ack_for_pos();
					end
					ST_SLA_R_NACK, ST_RX_NACK: begin
						shadow_busy = 1'b0;
						a.send_stop = 1'b1;
					end
					default: begin
						a.clear_interrupt = 1'b0;
					end
				endcase
			end
		endcase
		a.busy = shadow_busy;
		return a;
	endfunction

	task automatic push_cmd(opcode_t op, logic [6:0] addr, logic [4:0] cnt, logic [3:0] idx,
		byte_t ld, byte_t st, byte_t rx);
		bus_cmd_t c;
		c.op = op;
		c.addr = addr;
		c.cnt = cnt;
		c.idx = idx;
		c.ld = ld;
		c.status = st;
		c.rx = rx;
		c.drain_first = drain_next;
		drain_next = 1'b0;
		pending_cmds.push_back(c);
	endtask

	task automatic push_load(logic [3:0] idx, byte_t ld);
		push_cmd(OP_LOAD, 7'($urandom), 5'($urandom), idx, ld, 8'($urandom), 8'($urandom));
	endtask

	task automatic push_start(opcode_t op, logic [6:0] addr, logic [4:0] cnt);
		push_cmd(op, addr, cnt, 4'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
	endtask

	task automatic push_status(byte_t st, byte_t rx);
		push_cmd(OP_STATUS, 7'($urandom), 5'($urandom), 4'($urandom), 8'($urandom), st, rx);
	endtask

	function automatic logic [4:0] pick_count();
		if ($urandom_range(0, 9) == 0)
			return $urandom_range(0, 1) ? 5'd0 : 5'($urandom_range(17, 31));
		return 5'($urandom_range(1, 16));
	endfunction

	task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
		if (got !== want) begin
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch on %s: expected %0h, got %0h", name, want, got);
		end
	endtask

	// input side: one item offered at a time, random gaps while 100 or more commands are queued
	always @(negedge clk) begin
		if (arst_n && (!in_valid || accepted_count == offered_count)) begin
			if (send_gap > 0) begin
				send_gap--;
				in_valid <= 1'b0;
			end else if (pending_cmds.size() == 0 ||
				(pending_cmds[0].drain_first && pending_actions.size() != 0)) begin
				in_valid <= 1'b0;
			end else begin
				cur_cmd = pending_cmds.pop_front();
				opcode <= cur_cmd.op;
				target_address <= cur_cmd.addr;
				byte_count <= cur_cmd.cnt;
				buffer_index <= cur_cmd.idx;
				load_byte <= cur_cmd.ld;
				status_code <= cur_cmd.status;
				rx_byte <= cur_cmd.rx;
				in_valid <= 1'b1;
				offered_count++;
				if (pending_cmds.size() >= 100 && $urandom_range(0, 9) == 0)
					send_gap = $urandom_range(1, 6);
			end
		end
	end

	// output side: short stalls, plus one long hold-off to back the block up
	always @(negedge clk) begin
		if (arst_n) begin
			if (!long_hold_done && accepted_count >= 250) begin
				hold_left = 60;
				long_hold_done = 1'b1;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else if (pending_cmds.size() >= 100 && $urandom_range(0, 9) == 0) begin
				stall_left = $urandom_range(1, 6) - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		ctrl_action_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (pending_actions.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result with nothing expected: tx %0h stop %0b busy %0b",
							tx_byte, send_stop, busy_res);
				end else begin
					want = pending_actions.pop_front();
					check_field("tx_valid", 8'(want.tx_valid), 8'(tx_valid));
					check_field("tx_byte", want.tx_byte, tx_byte);
					check_field("send_start", 8'(want.send_start), 8'(send_start));
					check_field("send_stop", 8'(want.send_stop), 8'(send_stop));
					check_field("ack_control", 8'(want.ack), 8'(ack_control));
					check_field("clear_start", 8'(want.clear_start), 8'(clear_start));
					check_field("clear_interrupt", 8'(want.clear_interrupt),
						8'(clear_interrupt));
					check_field("rx_valid", 8'(want.rx_valid), 8'(rx_valid));
					check_field("rx_data", want.rx_data, rx_data);
					check_field("rx_position", 8'(want.rx_pos), 8'(rx_position));
					check_field("busy_res", 8'(want.busy), 8'(busy_res));
					check_field("start_rejected", 8'(want.rejected), 8'(start_rejected));
				end
			end
			if (in_valid && in_ready) begin
				pending_actions.push_back(bus_controller_action(cur_cmd));
				accepted_count++;
			end
		end
	end

	initial begin
		int  kind;
		int  eff;
		int  k;
		logic [4:0] n;
		bit  drain_marked;
		drain_marked = 1'b0;

		// fill the whole buffer first so no entry is ever read unwritten
		for (k = 0; k < DEPTH; k++)
			push_load(4'(k), (k == 0) ? 8'h00 : (k == 1) ? 8'hFF : 8'($urandom));
		push_start(OP_START_WR, 7'h7F, 5'd1);
		push_start(OP_START_RD, 7'h00, 5'd31);          // rejected, busy
		push_load(4'hF, 8'hAA);                         // ignored, busy
		push_status(ST_START_SENT, 8'h00);
		push_status(ST_SLA_W_ACK, 8'hFF);
		push_status(ST_DATA_ACK, 8'h00);                // count reached: stop
		push_start(OP_START_RD, 7'h00, 5'd0);           // zero count read
		push_status(ST_SLA_R_ACK, 8'h00);               // NACK
		push_status(ST_RX_NACK, 8'hFF);
		push_status(8'h00, 8'h00);                      // unknown code while idle
		push_start(OP_START_WR, 7'h2A, 5'd31);          // count clamps to depth
		push_status(ST_SLA_R_NACK, 8'h5A);

		while (pending_cmds.size() < 700) begin
			if (!drain_marked && pending_cmds.size() >= 450) begin
				drain_next = 1'b1;
				drain_marked = 1'b1;
			end
			kind = $urandom_range(0, 99);
			n = pick_count();
			eff = (n > DEPTH) ? DEPTH : n;
			if (kind < 30) begin
				repeat ($urandom_range(0, 3))
					push_load(4'($urandom), 8'($urandom));
				push_start(OP_START_WR, 7'($urandom), n);
				push_status(ST_START_SENT, 8'($urandom));
				push_status(ST_SLA_W_ACK, 8'($urandom));
				for (k = 1; k < eff; k++)
					push_status(ST_DATA_ACK, 8'($urandom));
				push_status(ST_DATA_ACK, 8'($urandom));
			end else if (kind < 60) begin
				push_start(OP_START_RD, 7'($urandom), n);
				push_status(ST_START_SENT, 8'($urandom));
				push_status(ST_SLA_R_ACK, 8'($urandom));
				for (k = 1; k < eff; k++)
					push_status(ST_RX_ACK, 8'($urandom));
				push_status(ST_RX_NACK, 8'($urandom));
			end else if (kind < 68) begin
				push_start(OP_START_RD, 7'($urandom), n);
				push_status(ST_START_SENT, 8'($urandom));
				push_status(ST_SLA_R_NACK, 8'($urandom));
			end else if (kind < 73) begin
				// runs the position past the buffer end until it saturates
				push_start($urandom_range(0, 1) ? OP_START_RD : OP_START_WR, 7'($urandom), n);
				push_status(ST_START_SENT, 8'($urandom));
				repeat ($urandom_range(33, 40))
					push_status($urandom_range(0, 1) ? ST_SLA_W_ACK : ST_RX_ACK, 8'($urandom));
				push_status(ST_SLA_R_NACK, 8'($urandom));
			end else if (kind < 88) begin
				repeat ($urandom_range(1, 4))
					push_cmd(opcode_t'($urandom_range(0, 3)), 7'($urandom), 5'($urandom),
						4'($urandom), 8'($urandom),
						$urandom_range(0, 1) ? 8'($urandom) : known_codes[$urandom_range(0, 6)],
						8'($urandom));
				if ($urandom_range(0, 1))
					push_status(ST_SLA_R_NACK, 8'($urandom));
			end else begin
				repeat ($urandom_range(1, 4))
					push_load(4'($urandom), 8'($urandom));
			end
		end

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending_cmds.size() != 0 || accepted_count != offered_count)
			@(posedge clk);
		while (pending_actions.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatches == 0 && pending_actions.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	initial begin
		#3000000;
		$display("FAIL");
		$finish;
	end

endmodule
